// ===== rtl/first_substring_match_finder_macros.svh =====
// assertion macros for the first substring match finder
`ifndef FIRST_SUBSTRING_MATCH_FINDER_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_MACROS_SVH
`ifndef SYNTHESIS
`define FSMF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FSMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define FSMF_ASSERT(label, clk, rst_n, prop, msg)
`define FSMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/fsmf_pkg.sv =====
// shared constants and types for the first substring match finder
package fsmf_pkg;
    localparam int MAX_PATTERN   = 16;
    localparam int POSITION_BITS = 32;
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
    localparam int START_BITS    = 32;
    localparam int OUT_BITS      = START_BITS + 2;
    localparam int OUT_BYTES_W   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    typedef logic [MAX_PATTERN-1:0][7:0] byte_vec_t;
    typedef logic [LEN_BITS-1:0]         len_t;
    typedef logic [POSITION_BITS-1:0]    pos_t;
endpackage

// ===== rtl/fsmf_match.sv =====
// parallel compare of the text window with the stored pattern
module fsmf_match (
    input  fsmf_pkg::byte_vec_t window,   // entry 0 newest text byte
    input  fsmf_pkg::byte_vec_t pattern,  // entry 0 last pattern byte
    input  fsmf_pkg::len_t      length,
    output logic                match
);
    import fsmf_pkg::*;

    logic [MAX_PATTERN-1:0] lane_ok;

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            // lanes beyond the pattern length always pass
            lane_ok[j] = (window[j] == pattern[j]) || (len_t'(j) >= length);
        end
        match = &lane_ok;
    end
endmodule

// ===== rtl/first_substring_match_finder.sv =====
// a final text byte passes from the input register into the result register
// throughput: one input byte per cycle except while stalled; the window compare and state update are combinational
// a stall only occurs when a final text byte meets an untaken result
// reset: asynchronous active-low rst_n clears pattern, text and handshake state
// the pattern store and text window hold undefined data after reset
module first_substring_match_finder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic                             s_axis_tuser,  // [0] kind
    input  logic                             s_axis_tlast,  // last
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] found, [32:1] match_start, [33] pattern_overflow, rest zero
    output logic [fsmf_pkg::OUT_BYTES_W-1:0] m_axis_tdata
);
    import fsmf_pkg::*;
    `include "first_substring_match_finder_macros.svh"

    localparam pos_t POS_MAX = '1;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // search state
    byte_vec_t pattern_reg, pattern_next;
    byte_vec_t window_reg, window_next;
    len_t      pattern_length_reg, pattern_length_next;
    logic      pattern_closed_reg, pattern_closed_next;
    logic      overflow_flag_reg, overflow_flag_next;
    pos_t      text_count_reg, text_count_next;
    logic      match_latched_reg, match_latched_next;
    pos_t      first_match_reg, first_match_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_found_reg, out_found_next;
    logic [START_BITS-1:0] out_start_reg, out_start_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic      in_accept;
    logic      proc_ok;
    logic      proc_fire;
    logic      out_load;
    logic      window_match;
    byte_vec_t window_shift;
    len_t      base_length;
    logic [POSITION_BITS:0] start_calc;

    assign proc_ok   = !(in_kind_reg == KIND_TEXT && in_last_reg) || !out_valid_reg
                       || m_axis_tready;
    assign proc_fire = in_valid_reg && proc_ok;
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = in_accept ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);

    // window with the registered byte shifted in as the newest entry
    assign window_shift = {window_reg[MAX_PATTERN-2:0], in_byte_reg};

    fsmf_match u_match (
        .window  (window_shift),
        .pattern (pattern_reg),
        .length  (pattern_length_reg),
        .match   (window_match)
    );

    always_comb
    begin
        pattern_next        = pattern_reg;
        window_next         = window_reg;
        pattern_length_next = pattern_length_reg;
        pattern_closed_next = pattern_closed_reg;
        overflow_flag_next  = overflow_flag_reg;
        text_count_next     = text_count_reg;
        match_latched_next  = match_latched_reg;
        first_match_next    = first_match_reg;
        out_load            = 1'b0;
        out_found_next      = out_found_reg;
        out_start_next      = out_start_reg;
        out_ovf_next        = out_ovf_reg;
        base_length         = pattern_length_reg;
        start_calc          = {1'b0, text_count_reg} + (POSITION_BITS+1)'(1)
                              - (POSITION_BITS+1)'(pattern_length_reg);

        if (proc_fire && in_kind_reg == KIND_PATTERN)
        begin
            if (pattern_closed_reg)
            begin
                // new pattern drops the old one and any search in progress
                base_length         = '0;
                overflow_flag_next  = 1'b0;
                pattern_closed_next = 1'b0;
                text_count_next     = '0;
                match_latched_next  = 1'b0;
                first_match_next    = '0;
            end
            if (base_length < len_t'(MAX_PATTERN))
            begin
                pattern_next        = {pattern_reg[MAX_PATTERN-2:0], in_byte_reg};
                pattern_length_next = base_length + len_t'(1);
            end
            else
            begin
                pattern_length_next = base_length;
                overflow_flag_next  = 1'b1;
            end
            if (in_last_reg)
            begin
                pattern_closed_next = 1'b1;
            end
        end
        else if (proc_fire)
        begin
            pattern_closed_next = 1'b1;
            window_next         = window_shift;
            if (text_count_reg != POS_MAX)
            begin
                text_count_next = text_count_reg + pos_t'(1);
            end
            if (!match_latched_reg)
            begin
                if (pattern_length_reg == '0)
                begin
                    match_latched_next = 1'b1;
                    first_match_next   = '0;
                end
                else if (text_count_next >= pos_t'(pattern_length_reg) && window_match)
                begin
                    match_latched_next = 1'b1;
                    first_match_next   = start_calc[POSITION_BITS-1:0];
                end
            end
            if (in_last_reg)
            begin
                out_load           = 1'b1;
                out_found_next     = match_latched_next;
                out_start_next     = match_latched_next ? START_BITS'(first_match_next) : '0;
                out_ovf_next       = overflow_flag_reg;
                text_count_next    = '0;
                match_latched_next = 1'b0;
                first_match_next   = '0;
            end
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            pattern_length_reg <= '0;
            pattern_closed_reg <= 1'b0;
            overflow_flag_reg  <= 1'b0;
            text_count_reg     <= '0;
            match_latched_reg  <= 1'b0;
            first_match_reg    <= '0;
        end
        else
        begin
            in_valid_reg       <= in_valid_next;
            out_valid_reg      <= out_valid_next;
            pattern_length_reg <= pattern_length_next;
            pattern_closed_reg <= pattern_closed_next;
            overflow_flag_reg  <= overflow_flag_next;
            text_count_reg     <= text_count_next;
            match_latched_reg  <= match_latched_next;
            first_match_reg    <= first_match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        pattern_reg   <= pattern_next;
        window_reg    <= window_next;
        out_found_reg <= out_found_next;
        out_start_reg <= out_start_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_BYTES_W'({out_ovf_reg, out_start_reg, out_found_reg});

    `FSMF_ASSERT(a_len_range, clk, rst_n,
        pattern_length_reg <= len_t'(MAX_PATTERN), "pattern length out of range")
    `FSMF_ASSERT_IMPL(a_ovf_full, clk, rst_n, overflow_flag_reg,
        pattern_length_reg == len_t'(MAX_PATTERN), "overflow with pattern not full")
    `FSMF_ASSERT_IMPL(a_no_result_loss, clk, rst_n, out_valid_reg && !m_axis_tready,
        !out_load, "result overwritten while stalled")
    `FSMF_ASSERT_IMPL(a_not_found_zero, clk, rst_n, out_valid_reg && !out_found_reg,
        out_start_reg == '0, "start set without a match")
endmodule

// ===== sim/tb_first_substring_match_finder.sv =====
// self-checking testbench for the first substring match finder: random pattern/text streams
`timescale 1ns / 100ps

module tb_first_substring_match_finder;
    import fsmf_pkg::*;

    localparam int   RUN_LIMIT    = 400000;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   ITEM_TARGET  = 2000;
    localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } search_item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] start;
        logic        overflow;
    } search_report_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;
    logic                   s_axis_tuser  = KIND_PATTERN;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;

    first_substring_match_finder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    search_item_t   byte_stream [$];
    search_report_t search_reports [$];
    search_item_t   next_item;
    search_item_t   seen_item;

    int  items_built   = 0;
    int  items_taken   = 0;
    int  reports_seen  = 0;
    int  reports_found = 0;
    int  reports_ovf   = 0;
    int  errors        = 0;
    int  send_gap      = 0;
    int  sink_stall    = 0;
    int  sink_draw     = 0;
    int  calm_left     = 0;
    bit  calm          = 1'b0;
    longint cycles     = 0;

    // predictor state
    logic [7:0]  pat_bytes [MAX_PATTERN];
    int          pat_len;
    bit          pat_closed;
    bit          pat_overflow;
    logic [7:0]  win [MAX_PATTERN];
    logic [63:0] text_seen;
    bit          hit_latched;
    logic [63:0] hit_index;

    // most gaps short, a few long, none during calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] base, input int span);
        if (span >= 256)
            return 8'($urandom_range(0, 255));
        return base + 8'($urandom_range(0, span - 1));
    endfunction

    task automatic push_item(input logic kind, input logic [7:0] data, input logic last);
        search_item_t it;
        it.kind = kind;
        it.data = data;
        it.last = last;
        byte_stream.push_back(it);
        items_built++;
    endtask

    task automatic clear_text();
        for (int k = 0; k < MAX_PATTERN; k++)
            win[k] = 8'h00;
        text_seen   = '0;
        hit_latched = 1'b0;
        hit_index   = '0;
    endtask

    function automatic bit window_hit();
        for (int k = 0; k < pat_len; k++)
            if (win[pat_len - 1 - k] != pat_bytes[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // the position count saturates only after 2^POSITION_BITS - 1 text bytes, far beyond this run
    task automatic track_search(input search_item_t it);
        logic [63:0]    idx;
        logic [63:0]    start;
        search_report_t rep;
        if (it.kind == KIND_PATTERN) begin
            if (pat_closed) begin
                pat_len      = 0;
                pat_overflow = 1'b0;
                pat_closed   = 1'b0;
                clear_text();
            end
            if (pat_len < MAX_PATTERN) begin
                pat_bytes[pat_len] = it.data;
                pat_len++;
            end else begin
                pat_overflow = 1'b1;
            end
            if (it.last)
                pat_closed = 1'b1;
        end else begin
            pat_closed = 1'b1;
            idx = text_seen;
            if (text_seen < POS_LIMIT)
                text_seen++;
            for (int k = MAX_PATTERN - 1; k > 0; k--)
                win[k] = win[k - 1];
            win[0] = it.data;
            if (!hit_latched) begin
                if (pat_len == 0) begin
                    hit_latched = 1'b1;
                    hit_index   = '0;
                end else if (text_seen >= pat_len && window_hit()) begin
                    hit_latched = 1'b1;
                    hit_index   = idx + 64'd1 - pat_len;
                end
            end
            if (it.last) begin
                start = hit_latched ? hit_index : 64'd0;
                if (start > 64'hFFFF_FFFF)
                    start = 64'hFFFF_FFFF;
                rep.found    = hit_latched;
                rep.start    = start[31:0];
                rep.overflow = pat_overflow;
                search_reports.push_back(rep);
                clear_text();
            end
        end
    endtask

    task automatic check_report(input logic [OUT_BYTES_W-1:0] raw);
        search_report_t got;
        search_report_t want;
        got.found    = raw[0];
        got.start    = raw[32:1];
        got.overflow = raw[33];
        reports_seen++;
        if (got.found)
            reports_found++;
        if (got.overflow)
            reports_ovf++;
        if (search_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: unexpected result found=%0b start=%0d overflow=%0b",
                         got.found, got.start, got.overflow);
        end else begin
            want = search_reports.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: result %0d expected found=%0b start=%0d overflow=%0b,",
                              " got found=%0b start=%0d overflow=%0b"},
                             reports_seen, want.found, want.start, want.overflow,
                             got.found, got.start, got.overflow);
            end
        end
    endtask

    // one pattern followed by a few texts, with near misses and occasional breaks
    task automatic add_search_run();
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        logic [7:0] base;
        int span, plen, eff, ntext, pre, post, r, at;
        bit unterminated;
        base = 8'($urandom_range(0, 255));
        span = $urandom_range(0, 2) == 0 ? 256 : $urandom_range(1, 3);
        r    = $urandom_range(0, 99);
        plen = r < 65 ? $urandom_range(1, 4) :
               r < 85 ? $urandom_range(5, MAX_PATTERN - 1) :
                        $urandom_range(MAX_PATTERN, MAX_PATTERN + 4);
        for (int i = 0; i < plen; i++)
            pat.push_back(pick_byte(base, span));
        unterminated = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < plen; i++)
            push_item(KIND_PATTERN, pat[i], (i == plen - 1) && !unterminated);
        eff   = plen > MAX_PATTERN ? MAX_PATTERN : plen;
        ntext = $urandom_range(1, 4);
        for (int t = 0; t < ntext; t++) begin
            txt.delete();
            pre  = $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 8);
            post = $urandom_range(0, 8);
            for (int i = 0; i < pre; i++)
                txt.push_back(pick_byte(base, span));
            if ($urandom_range(0, 9) < 6) begin
                at = txt.size();
                for (int i = 0; i < eff; i++)
                    txt.push_back(pat[i]);
                if ($urandom_range(0, 9) < 3)
                    txt[at + $urandom_range(0, eff - 1)] ^= 8'($urandom_range(1, 255));
            end
            for (int i = 0; i < post; i++)
                txt.push_back(pick_byte(base, span));
            if (txt.size() == 0)
                txt.push_back(pick_byte(base, span));
            for (int i = 0; i < txt.size(); i++) begin
                // a stray pattern byte restarts the pattern mid-text
                if ($urandom_range(0, 199) == 0)
                    push_item(KIND_PATTERN, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                push_item(KIND_TEXT, txt[i], i == txt.size() - 1);
            end
        end
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 400);
        end else begin
            calm_left <= calm_left - 1;
        end
        if (cycles >= RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_first_substring_match_finder: FAIL");
            $finish;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_PATTERN;
            s_axis_tlast  <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (byte_stream.size() != 0) begin
                next_item = byte_stream.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_item.kind;
                s_axis_tdata  <= next_item.data;
                s_axis_tlast  <= next_item.last;
                send_gap      <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random back-pressure
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end else if (sink_stall != 0) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= sink_stall - 1;
        end else begin
            sink_draw = pick_gap();
            m_axis_tready <= (sink_draw == 0);
            sink_stall    <= sink_draw == 0 ? 0 : sink_draw - 1;
        end
    end

    // monitor: check results first, then feed the accepted transfer to the predictor
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                seen_item.kind = s_axis_tuser;
                seen_item.data = s_axis_tdata;
                seen_item.last = s_axis_tlast;
                track_search(seen_item);
                items_taken++;
            end
        end
    end

    initial begin
        for (int k = 0; k < MAX_PATTERN; k++)
            pat_bytes[k] = 8'h00;
        pat_len      = 0;
        pat_closed   = 1'b0;
        pat_overflow = 1'b0;
        clear_text();

        // empty pattern right after reset matches at position 0
        push_item(KIND_TEXT, 8'h00, 1'b0);
        push_item(KIND_TEXT, 8'hFF, 1'b1);
        // two-byte pattern at the byte extremes, found at index 1
        push_item(KIND_PATTERN, 8'hFF, 1'b0);
        push_item(KIND_PATTERN, 8'h00, 1'b1);
        push_item(KIND_TEXT, 8'h00, 1'b0);
        push_item(KIND_TEXT, 8'hFF, 1'b0);
        push_item(KIND_TEXT, 8'h00, 1'b1);
        // same pattern kept, no match this time
        push_item(KIND_TEXT, 8'h41, 1'b1);
        // text arriving while the pattern is still open closes it
        push_item(KIND_PATTERN, 8'hAA, 1'b0);
        push_item(KIND_TEXT, 8'hAA, 1'b1);
        // new pattern in the middle of a text drops the text in progress
        push_item(KIND_TEXT, 8'h12, 1'b0);
        push_item(KIND_PATTERN, 8'h55, 1'b1);
        push_item(KIND_TEXT, 8'h55, 1'b1);

        while (items_built < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 5))
                    push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end else begin
                add_search_run();
            end
        end
        // finish the stream with a closed text so nothing is left half done
        push_item(KIND_TEXT, 8'($urandom_range(0, 255)), 1'b1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_stream.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (search_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d byte transfers, checked %0d search results", items_taken, reports_seen);
        $display("results with a match: %0d, with dropped pattern bytes: %0d, mismatches: %0d",
                 reports_found, reports_ovf, errors);
        if (errors == 0 && search_reports.size() == 0)
            $display("tb_first_substring_match_finder: PASS");
        else
            $display("tb_first_substring_match_finder: FAIL");
        $finish;
    end

endmodule
